/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("%m: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("%m: next-cycle check failed");

`endif

/* rtl/core/deq_pkg.sv */
package deq_pkg;

	// operation codes carried by func
	typedef enum logic [2:0] {
		FUNC_PUSH_FRONT = 3'd0,
		FUNC_PUSH_BACK  = 3'd1,
		FUNC_DUMP       = 3'd2,
		FUNC_POP_FRONT  = 3'd3,
		FUNC_POP_BACK   = 3'd4
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// control states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_BUSY = 1'b1
	} state_t;

	localparam int unsigned WORD_W = 32;

endpackage

/* rtl/core/deq_ram.sv */
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port; read data holds when re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/double_ended_queue_top.sv */
// channel   signals                         direction
// input     in_valid, in_ready, func, value  into the block
// output    out_valid, out_ready, value_res, status, last  out of the block
//
// push: the status word is registered at accept.
// pop: one ring memory read, then the output register.
// dump: the stored words front to back, one per cycle after the first read,
//   paced by the single memory read port and by out_ready.
// reset clears pointers, occupancy and control; the ring needs no clearing.
// a new word is taken only when idle and the output register is free or draining.
`include "assert_macros.svh"

module double_ended_queue_top #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value_res,
	output logic [1:0]         status,
	output logic               last
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;

	// ring slot add with wrap, both operands below DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [SW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + b;
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	deq_pkg::state_t  state_q, state_d;
	logic [AW-1:0]    front_q, front_d;
	logic [OW-1:0]    occ_q, occ_d;
	logic [AW-1:0]    slot_q, slot_d;
	logic [OW-1:0]    left_q, left_d;
	logic             rd_s1, rd_d;
	logic             rd_last_s1, rd_last_d;

	logic             out_valid_q;
	logic [31:0]      value_res_q;
	deq_pkg::status_t status_q;
	logic             last_q;

	logic             in_acc;
	logic             out_load;
	deq_pkg::status_t out_status;
	logic             mem_load;
	logic             issue;
	logic             full;
	logic             empty;
	logic [AW-1:0]    front_dec;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [31:0]      ram_rdata;

	// ring store
	deq_ram #(
		.WIDTH (deq_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign full      = (occ_q == OW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

	// next state, memory control and result selection
	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		occ_d      = occ_q;
		slot_d     = slot_q;
		left_d     = left_q;
		rd_d       = rd_s1;
		rd_last_d  = rd_last_s1;
		in_ready   = (state_q == deq_pkg::S_IDLE) && (!out_valid_q || out_ready);
		in_acc     = in_valid && in_ready;
		out_load   = 1'b0;
		out_status = deq_pkg::STAT_OK;
		mem_load   = 1'b0;
		issue      = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = front_dec;
		ram_re     = 1'b0;
		ram_raddr  = slot_q;

		if (state_q == deq_pkg::S_IDLE) begin
			if (in_acc) begin
				case (func)
					deq_pkg::FUNC_PUSH_FRONT: begin
						out_load = 1'b1;
						if (full) begin
							out_status = deq_pkg::STAT_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = front_dec;
							front_d   = front_dec;
							occ_d     = occ_q + OW'(1);
						end
					end
					deq_pkg::FUNC_PUSH_BACK: begin
						out_load = 1'b1;
						if (full) begin
							out_status = deq_pkg::STAT_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = wrap_add(front_q, SW'(occ_q));
							occ_d     = occ_q + OW'(1);
						end
					end
					deq_pkg::FUNC_DUMP: begin
						if (empty) begin
							out_load   = 1'b1;
							out_status = deq_pkg::STAT_EMPTY;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = front_q;
							rd_d      = 1'b1;
							rd_last_d = (occ_q == OW'(1));
							left_d    = occ_q - OW'(1);
							slot_d    = wrap_add(front_q, SW'(1));
							state_d   = deq_pkg::S_BUSY;
						end
					end
					deq_pkg::FUNC_POP_FRONT: begin
						if (empty) begin
							out_load   = 1'b1;
							out_status = deq_pkg::STAT_EMPTY;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = front_q;
							rd_d      = 1'b1;
							rd_last_d = 1'b1;
							left_d    = '0;
							front_d   = wrap_add(front_q, SW'(1));
							occ_d     = occ_q - OW'(1);
							state_d   = deq_pkg::S_BUSY;
						end
					end
					deq_pkg::FUNC_POP_BACK: begin
						if (empty) begin
							out_load   = 1'b1;
							out_status = deq_pkg::STAT_EMPTY;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = wrap_add(front_q, SW'(occ_q - OW'(1)));
							rd_d      = 1'b1;
							rd_last_d = 1'b1;
							left_d    = '0;
							occ_d     = occ_q - OW'(1);
							state_d   = deq_pkg::S_BUSY;
						end
					end
					default: begin
						out_load = 1'b0;
					end
				endcase
			end
		end else begin
			// walk: move held read data out, issue the next read behind it
			mem_load = rd_s1 && (!out_valid_q || out_ready);
			issue    = (left_q != '0) && (!rd_s1 || mem_load);
			if (issue) begin
				ram_re    = 1'b1;
				ram_raddr = slot_q;
				rd_d      = 1'b1;
				rd_last_d = (left_q == OW'(1));
				left_d    = left_q - OW'(1);
				slot_d    = wrap_add(slot_q, SW'(1));
			end else if (mem_load) begin
				rd_d = 1'b0;
				if (left_q == '0) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::S_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			slot_q      <= '0;
			left_q      <= '0;
			rd_s1       <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			occ_q      <= occ_d;
			slot_q     <= slot_d;
			left_q     <= left_d;
			rd_s1      <= rd_d;
			rd_last_s1 <= rd_last_d;
			if (out_load || mem_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			value_res_q <= '0;
			status_q    <= out_status;
			last_q      <= 1'b1;
		end else if (mem_load) begin
			value_res_q <= ram_rdata;
			status_q    <= deq_pkg::STAT_OK;
			last_q      <= rd_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign status    = status_q;
	assign last      = last_q;

	// checks
	`ASSERT_IMP(a_occ_range, clk, arst_n, 1'b1, occ_q <= OW'(DEPTH))
	`ASSERT_IMP(a_busy_holds_read, clk, arst_n, state_q == deq_pkg::S_BUSY, rd_s1)
	`ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, (state_q == deq_pkg::S_IDLE) && !rd_s1)
	`ASSERT_NXT(a_pop_reads, clk, arst_n,
		in_acc && !empty && (func == deq_pkg::FUNC_POP_FRONT || func == deq_pkg::FUNC_POP_BACK),
		state_q == deq_pkg::S_BUSY && rd_last_s1 && left_q == '0)

endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 64;
	localparam int RAND_WORDS  = 350;
	localparam int STUCK_LIMIT = 2000;
	localparam int SETTLE_CYC  = 20;

	// ports
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         func;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] value_res;
	logic [1:0]         status;
	logic               last;

	double_ended_queue_top #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_res (value_res),
		.status    (status),
		.last      (last)
	);

	typedef struct {
		logic signed [31:0] word;
		deq_pkg::status_t   st;
		logic               lst;
	} deque_result_t;

	// tb copy of the deque contents
	logic signed [31:0] ring_words [DEPTH];
	int                 ring_front = 0;
	int                 ring_count = 0;

	deque_result_t results_due [$];
	int            error_count = 0;
	int            burst_left  = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] ERROR: %s", $realtime, what);
	endtask

	task automatic due_result(input logic signed [31:0] w, input deq_pkg::status_t st,
		input logic lst);
		deque_result_t r;
		r.word = w;
		r.st   = st;
		r.lst  = lst;
		results_due.push_back(r);
	endtask

	// update the deque copy for one accepted word and queue what it must produce
	task automatic apply_deque_op(input logic [2:0] f, input logic signed [31:0] v);
		int slot;
		case (f)
			deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
				if (ring_count == DEPTH) begin
					due_result('0, deq_pkg::STAT_FULL, 1'b1);
				end else begin
					if (f == deq_pkg::FUNC_PUSH_FRONT) begin
						ring_front = (ring_front + DEPTH - 1) % DEPTH;
						slot = ring_front;
					end else begin
						slot = (ring_front + ring_count) % DEPTH;
					end
					ring_words[slot] = v;
					ring_count++;
					due_result('0, deq_pkg::STAT_OK, 1'b1);
				end
			end
			deq_pkg::FUNC_DUMP: begin
				if (ring_count == 0) begin
					due_result('0, deq_pkg::STAT_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < ring_count; i++)
						due_result(ring_words[(ring_front + i) % DEPTH], deq_pkg::STAT_OK,
							i == ring_count - 1);
				end
			end
			deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK: begin
				if (ring_count == 0) begin
					due_result('0, deq_pkg::STAT_EMPTY, 1'b1);
				end else begin
					if (f == deq_pkg::FUNC_POP_FRONT) begin
						slot = ring_front;
						ring_front = (ring_front + 1) % DEPTH;
					end else begin
						slot = (ring_front + ring_count - 1) % DEPTH;
					end
					ring_count--;
					due_result(ring_words[slot], deq_pkg::STAT_OK, 1'b1);
				end
			end
			default: begin
				// unused codes produce nothing
			end
		endcase
	endtask

	// drive one word in bursts with random gaps, wait for accept
	task automatic send_word(input logic [2:0] f, input logic signed [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		func     = f;
		value    = v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_deque_op(f, v);
	endtask

	// drop valid so the last word is not taken twice
	task automatic release_input();
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return -32'sd1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_pop();
		return $urandom_range(0, 1) ? deq_pkg::FUNC_POP_FRONT : deq_pkg::FUNC_POP_BACK;
	endfunction

	function automatic logic [2:0] pick_push();
		return $urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_FRONT : deq_pkg::FUNC_PUSH_BACK;
	endfunction

	// operations on an empty deque, plus the unused codes
	task automatic test_empty_ops();
		send_word(deq_pkg::FUNC_POP_FRONT, $urandom);
		send_word(deq_pkg::FUNC_POP_BACK, $urandom);
		send_word(deq_pkg::FUNC_DUMP, $urandom);
		send_word(3'd5, $urandom);
		send_word(3'd6, $urandom);
		send_word(3'd7, $urandom);
		send_word(deq_pkg::FUNC_DUMP, '0);
		release_input();
	endtask

	// extreme words at both ends, a held all-ones word popped as data
	task automatic test_extremes();
		send_word(deq_pkg::FUNC_PUSH_BACK, 32'sh7fffffff);
		send_word(deq_pkg::FUNC_PUSH_FRONT, 32'sh80000000);
		send_word(deq_pkg::FUNC_PUSH_BACK, -32'sd1);
		send_word(deq_pkg::FUNC_PUSH_FRONT, '0);
		send_word(deq_pkg::FUNC_PUSH_BACK, 32'sd1);
		send_word(deq_pkg::FUNC_DUMP, $urandom);
		send_word(deq_pkg::FUNC_POP_BACK, $urandom);
		send_word(deq_pkg::FUNC_POP_BACK, $urandom);
		send_word(deq_pkg::FUNC_POP_FRONT, $urandom);
		send_word(deq_pkg::FUNC_POP_FRONT, $urandom);
		send_word(deq_pkg::FUNC_POP_FRONT, $urandom);
		send_word(deq_pkg::FUNC_POP_FRONT, $urandom);
		release_input();
	endtask

	// fill to capacity, push into a full deque, dump all, drain to empty, pop the empty deque
	task automatic test_full_store();
		while (ring_count < DEPTH)
			send_word(pick_push(), pick_value());
		send_word(deq_pkg::FUNC_PUSH_FRONT, $urandom);
		send_word(deq_pkg::FUNC_PUSH_BACK, $urandom);
		send_word(deq_pkg::FUNC_DUMP, $urandom);
		while (ring_count > 0)
			send_word(pick_pop(), $urandom);
		send_word(deq_pkg::FUNC_POP_BACK, $urandom);
		release_input();
	endtask

	// random walk over fill level with dumps and noise codes
	task automatic test_random_mix();
		int sent;
		int mode_left;
		int push_pct;
		int r;
		sent      = 0;
		mode_left = 0;
		push_pct  = 50;
		while (sent < RAND_WORDS) begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(30, 80);
				case ($urandom_range(0, 2))
					0:       push_pct = 25;
					1:       push_pct = 50;
					default: push_pct = 75;
				endcase
			end
			mode_left--;
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_word(3'($urandom_range(5, 7)), $urandom);
			end else begin
				sent++;
				if (r < 8)
					send_word(deq_pkg::FUNC_DUMP, $urandom);
				else if ($urandom_range(0, 99) < push_pct)
					send_word(pick_push(), pick_value());
				else
					send_word(pick_pop(), $urandom);
			end
		end
		release_input();
	endtask

	// receiver stall pattern, changes style every so often
	initial begin
		int hold;
		int kind;
		int phase;
		out_ready = 1'b0;
		hold      = 0;
		kind      = 0;
		phase     = 0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				kind = $urandom_range(0, 3);
				hold = $urandom_range(20, 150);
			end
			hold--;
			phase++;
			case (kind)
				0:       out_ready = 1'b1;
				1:       out_ready = $urandom_range(0, 1);
				2:       out_ready = ($urandom_range(0, 3) == 0);
				default: out_ready = (phase % 8) < 3;
			endcase
		end
	end

	// compare each result word against the oldest one due
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %0d status %0d last %0b",
					value_res, status, last));
			end else begin
				want = results_due.pop_front();
				if (value_res !== want.word)
					report_mismatch($sformatf("value_res got %0d want %0d",
						value_res, want.word));
				if (status !== want.st)
					report_mismatch($sformatf("status got %0d want %0d", status, want.st));
				if (last !== want.lst)
					report_mismatch($sformatf("last got %0b want %0b", last, want.lst));
			end
		end
	end

	// watchdog on cycles with work pending and no handshake
	always @(posedge clk) begin
		int stuck;
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (!in_valid && results_due.size() == 0)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = '0;
		value    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_ops();
		test_extremes();
		test_full_store();
		test_random_mix();

		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue_top.sv
tb/tb.sv
